>>> sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge while reset is low.
`define ASSERT_DIS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> sv/ctc_pkg.sv
// Package with the types, constants and tables of the class transition counter.
`timescale 1ns / 1ps

package ctc_pkg;

  localparam int NUM_CLASSES   = 224;
  localparam int COUNT_BITS    = 16;
  localparam int HIGHEST_GROUP = 7;
  localparam int MIN_LEVEL     = 3;

  localparam int IDX_BITS    = 8;
  localparam int NUM_CELLS   = NUM_CLASSES * NUM_CLASSES;
  localparam int ADDR_BITS   = $clog2(NUM_CELLS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam int IN_TDATA_BITS  = 32;
  localparam int OUT_TDATA_BITS = 16;
  localparam int OUT_TUSER_BITS = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Work that the back part does for one item.
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,  // result without a memory access
    OP_READ = 2'd1,  // read one cell
    OP_INC  = 2'd2   // read, increment and write back one cell
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    op_t                  op;
    logic [ADDR_BITS-1:0] addr;
    logic                 invalid_class;
    logic                 out_of_level;
  } item_t;

  // Flat index of the first class of each group; past the last group it is the total.
  function automatic logic [8:0] group_start(input logic [3:0] g);
    logic [8:0] s;
    case (g)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd1;
      4'd3:    s = 9'd7;
      4'd4:    s = 9'd19;
      4'd5:    s = 9'd48;
      4'd6:    s = 9'd86;
      4'd7:    s = 9'd136;
      4'd8:    s = 9'd186;
      4'd9:    s = 9'd224;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

>>> sv/ctc_front.sv
// Front part: accepts items, classifies symbols and queries, tracks the previous class.
`timescale 1ns / 1ps

module ctc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // group [3:0], number [9:4], query_row [17:10], query_col [25:18], zero fill
  input  logic [ctc_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  // req_type
  input  logic                               s_axis_tuser,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_wdata,
  input  logic                               clear_busy,
  input  logic                               q_full,
  output logic                               push,
  output ctc_pkg::item_t                     push_item
);
  import ctc_pkg::*;

  logic [IDX_BITS-1:0] prev_index;
  logic                prev_valid;
  logic [2:0]          display_level;

  logic [3:0]          group;
  logic [5:0]          number;
  logic [7:0]          query_row;
  logic [7:0]          query_col;
  logic [3:0]          group_up;
  logic [8:0]          start_lo;
  logic [8:0]          start_hi;
  logic [8:0]          size;
  logic [8:0]          idx;
  logic                sym_ok;
  logic [2:0]          level;
  logic [8:0]          bound;
  logic                in_matrix;

  assign group     = s_axis_tdata[3:0];
  assign number    = s_axis_tdata[9:4];
  assign query_row = s_axis_tdata[17:10];
  assign query_col = s_axis_tdata[25:18];

  assign s_axis_tready = !clear_busy && !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  // Symbol checks and flat index.
  always_comb begin
    group_up = group + 4'd1;
    start_lo = group_start(group);
    start_hi = group_start(group_up);
    size     = start_hi - start_lo;
    idx      = start_lo + 9'(number) - 9'd1;
    sym_ok   = (group >= 4'd1) && (group <= 4'(HIGHEST_GROUP)) && (number != 6'd0) &&
               (9'(number) <= size) && (idx < 9'(NUM_CLASSES));
  end

  // Query bound from the display level, with low levels raised to the minimum.
  always_comb begin
    level     = (display_level < 3'(MIN_LEVEL)) ? 3'(MIN_LEVEL) : display_level;
    bound     = group_start(4'(level) + 4'd1);
    in_matrix = (9'(query_row) < 9'(NUM_CLASSES)) && (9'(query_col) < 9'(NUM_CLASSES));
  end

  // Classification of the item into the work for the back part.
  always_comb begin
    push_item = '0;
    if (s_axis_tuser) begin
      push_item.op           = in_matrix ? OP_READ : OP_NONE;
      push_item.addr         = ADDR_BITS'(32'(query_row) * 32'(NUM_CLASSES) + 32'(query_col));
      push_item.out_of_level = (9'(query_row) >= bound) || (9'(query_col) >= bound);
    end else if (!sym_ok) begin
      push_item.op            = OP_NONE;
      push_item.invalid_class = 1'b1;
    end else if (prev_valid && (9'(prev_index) < 9'(NUM_CLASSES))) begin
      push_item.op   = OP_INC;
      push_item.addr = ADDR_BITS'(32'(prev_index) * 32'(NUM_CLASSES) + 32'(idx));
    end else begin
      push_item.op = OP_NONE;
    end
  end

  // Chain state and the display level register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_index    <= '0;
      prev_valid    <= 1'b0;
      display_level <= 3'(MIN_LEVEL);
    end else begin
      if (cfg_we) begin
        display_level <= cfg_wdata;
      end
      if (push && !s_axis_tuser) begin
        if (sym_ok) begin
          prev_index <= idx[IDX_BITS-1:0];
          prev_valid <= 1'b1;
        end else begin
          prev_valid <= 1'b0;
        end
      end
    end
  end

endmodule

>>> sv/ctc_queue.sv
// Short queue of classified items between the front and the back part.
`timescale 1ns / 1ps

module ctc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ctc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output ctc_pkg::item_t head_item,
  output logic           not_empty
);
  import ctc_pkg::*;

  item_t                entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   fill;

  assign full      = (fill == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head_item = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> sv/ctc_back.sv
// Back part: counter memory, clearing sweep, read-modify-write and result register.
`timescale 1ns / 1ps

module ctc_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  ctc_pkg::item_t                      head_item,
  output logic                                pop,
  output logic                                clear_busy,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // count
  output logic [ctc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  // cell_set [0], invalid_class [1], out_of_level [2]
  output logic [ctc_pkg::OUT_TUSER_BITS-1:0]  m_axis_tuser
);
  import ctc_pkg::*;

  logic [COUNT_BITS-1:0] mem [NUM_CELLS];
  logic [COUNT_BITS-1:0] rd_data;

  state_t                state;
  state_t                state_next;
  item_t                 item;
  logic [ADDR_BITS-1:0]  clear_addr;

  logic                  out_free;
  logic                  clear_last;
  logic                  rd_en;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;
  logic                  load_out;
  logic [COUNT_BITS-1:0] cnt;

  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign clear_last = (clear_addr == ADDR_BITS'(NUM_CELLS - 1));
  assign clear_busy = (state == ST_CLEAR);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clear_last) state_next = ST_IDLE;
      ST_IDLE:  if (q_valid) state_next = ST_EXEC;
      ST_EXEC:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Count after the operation, saturating at the counter maximum.
  always_comb begin
    case (item.op)
      OP_READ: cnt = rd_data;
      OP_INC:  cnt = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
      default: cnt = '0;
    endcase
  end

  // Outputs of the sequencer: pop and read, memory write, result load.
  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = clear_addr;
    mem_wd   = '0;
    load_out = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        pop   = q_valid;
        rd_en = q_valid;
      end
      ST_EXEC: begin
        load_out = out_free;
        mem_we   = out_free && (item.op == OP_INC);
        mem_wa   = item.addr;
        mem_wd   = cnt;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Counter memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= mem[head_item.addr];
    end
  end

  // Item held while its cell is read.
  always_ff @(posedge clk) begin
    if (pop) begin
      item <= head_item;
    end
  end

  // Sequencer state and clearing sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  // Result register toward the output stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= OUT_TDATA_BITS'(cnt);
      m_axis_tuser <= {item.out_of_level, item.invalid_class, (cnt != '0)};
    end
  end

endmodule

>>> sv/class_transition_counter.sv
// A result passes the queue, the registered memory read and the result register.
// The back part pops no new item until the last one has left ST_EXEC for its result.
// The 4-entry queue lets the front keep taking items while the back is busy or stalled.
// Reset: synchronous; afterwards the memory is swept to zero, one cell per cycle,
// with s_axis_tready low; configuration writes are taken throughout.
`timescale 1ns / 1ps

module class_transition_counter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // group [3:0], number [9:4], query_row [17:10], query_col [25:18], zero fill
  input  logic [ctc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  // req_type
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // count
  output logic [ctc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  // cell_set [0], invalid_class [1], out_of_level [2]
  output logic [ctc_pkg::OUT_TUSER_BITS-1:0]  m_axis_tuser,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_wdata
);
  import ctc_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  item_t head_item;
  logic  q_valid;
  logic  clear_busy;

  // Classification and chain tracking.
  ctc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .clear_busy    (clear_busy),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  // Decoupling queue.
  ctc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_item (head_item),
    .not_empty (q_valid)
  );

  // Counter memory and results.
  ctc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head_item     (head_item),
    .pop           (pop),
    .clear_busy    (clear_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> sv/ctc_checker.sv
// Port checker for the class transition counter and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [ctc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  input logic [ctc_pkg::OUT_TUSER_BITS-1:0]  m_axis_tuser
);

  // The clearing sweep follows every reset, so no transfer is taken right after it.
  `ASSERT_ALWAYS(a_no_input_after_reset, clk, rst |=> !s_axis_tready)

  // A stalled result holds its valid and its payload.
  `ASSERT_DIS(a_result_holds, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

  // An invalid symbol never reports a count.
  `ASSERT_DIS(a_invalid_no_count, clk, rst, (m_axis_tvalid && m_axis_tuser[1]) |-> ((m_axis_tdata == '0) && !m_axis_tuser[0]))

  // An invalid symbol result never carries the level flag.
  `ASSERT_DIS(a_flags_exclusive, clk, rst, m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tuser[2]))

endmodule

bind class_transition_counter ctc_checker u_ctc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> bench/testbench.sv
// Self-checking testbench for the class transition counter.
`timescale 1ns / 1ps

module testbench;
  import ctc_pkg::*;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_SYMBOL = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  localparam int STALL_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LAST_CLASS    = 185;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 230;
  localparam int POOL_SIZE     = 6;
  localparam int RUN_LENGTH    = 70;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  cell_set;
    logic                  invalid_class;
    logic                  out_of_level;
  } outcome_t;

  logic                      clk;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
  logic                      s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic [OUT_TUSER_BITS-1:0] m_axis_tuser;
  logic                      cfg_we;
  logic [2:0]                cfg_wdata;

  // Shadow copy of the block state used to predict each result.
  bit [COUNT_BITS-1:0] tally [NUM_CELLS];
  int unsigned         group_base [10] = '{0, 0, 1, 7, 19, 48, 86, 136, 186, 224};
  int unsigned         last_class;
  bit                  last_valid;
  logic [2:0]          level_now;
  outcome_t            pending_outcomes [$];

  int error_count;
  int idle_cycles;
  bit src_idling;
  bit sink_idling;
  int sink_stall;

  class_transition_counter DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Works out the result of one request and updates the shadow state.
  function automatic outcome_t predict_outcome(input logic kind, input logic [31:0] word);
    logic [3:0]  grp;
    logic [5:0]  num;
    logic [7:0]  row;
    logic [7:0]  col;
    int unsigned lvl;
    int unsigned limit;
    int unsigned idx;
    int unsigned slot;
    bit          ok;
    outcome_t    res;
    grp = word[3:0];
    num = word[9:4];
    row = word[17:10];
    col = word[25:18];
    res = '0;
    if (kind == REQ_QUERY) begin
      lvl = (level_now < MIN_LEVEL) ? MIN_LEVEL : level_now;
      limit = group_base[lvl + 1];
      if (row < NUM_CLASSES && col < NUM_CLASSES) begin
        res.count = tally[row * NUM_CLASSES + col];
      end
      res.out_of_level = (row >= limit || col >= limit);
    end else begin
      ok = (grp >= 1 && grp <= HIGHEST_GROUP && num >= 1);
      idx = 0;
      if (ok) begin
        idx = group_base[grp] + num - 1;
        ok = (num <= group_base[grp + 1] - group_base[grp]) && idx < NUM_CLASSES;
      end
      if (!ok) begin
        // A bad symbol breaks the chain and touches no entry.
        res.invalid_class = 1'b1;
        last_valid = 1'b0;
      end else begin
        if (last_valid) begin
          slot = last_class * NUM_CLASSES + idx;
          if (tally[slot] != COUNT_MAX) begin
            tally[slot] = tally[slot] + 1'b1;
          end
          res.count = tally[slot];
        end
        last_class = idx;
        last_valid = 1'b1;
      end
    end
    res.cell_set = (res.count != 0);
    return res;
  endfunction

  // Splits a flat class index into its group and number.
  function automatic void class_of(input int unsigned idx, output logic [3:0] grp,
                                   output logic [5:0] num);
    grp = 4'd1;
    num = 6'd1;
    for (int g = 1; g <= HIGHEST_GROUP; g++) begin
      if (idx >= group_base[g] && idx < group_base[g + 1]) begin
        grp = 4'(g);
        num = 6'(idx - group_base[g] + 1);
      end
    end
  endfunction

  // Track configuration writes, predict on input transfers, check output transfers.
  always @(posedge clk) begin : monitor
    outcome_t want;
    outcome_t got;
    bit       moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_we) begin
        level_now = cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready === 1'b1) begin
        pending_outcomes.push_back(predict_outcome(s_axis_tuser, s_axis_tdata));
        moved = 1'b1;
      end
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        moved = 1'b1;
        got.count = m_axis_tdata;
        got.cell_set = m_axis_tuser[0];
        got.invalid_class = m_axis_tuser[1];
        got.out_of_level = m_axis_tuser[2];
        if (pending_outcomes.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected result: count=%0d set=%b invalid=%b out_of_level=%b",
                     got.count, got.cell_set, got.invalid_class, got.out_of_level);
          end
        end else begin
          want = pending_outcomes.pop_front();
          if (got.count !== want.count || got.cell_set !== want.cell_set ||
              got.invalid_class !== want.invalid_class ||
              got.out_of_level !== want.out_of_level) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch: expected count=%0d set=%b invalid=%b out_of_level=%b",
                       want.count, want.cell_set, want.invalid_class, want.out_of_level);
              $display("          actual   count=%0d set=%b invalid=%b out_of_level=%b",
                       got.count, got.cell_set, got.invalid_class, got.out_of_level);
            end
          end
        end
      end
      // Watchdog on cycles without any transfer.
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Result receiver with random stall bursts.
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else if (sink_idling && $urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Sends one request and returns once its transfer has happened; tvalid stays high.
  task automatic send_request(input logic kind, input logic [3:0] grp, input logic [5:0] num,
                              input logic [7:0] row, input logic [7:0] col);
    int gap;
    gap = 0;
    if (src_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
    end
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {6'b0, col, row, num, grp};
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted result has arrived.
  task automatic await_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the display level once the block has gone idle.
  task automatic set_display_level(input logic [2:0] value);
    await_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Chain start, extreme classes, each kind of bad symbol and basic queries.
  task automatic test_chain_basics();
    send_request(REQ_SYMBOL, 4'd1, 6'd1, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd7, 6'd50, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd7, 6'd50, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd1, 6'd1, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd1, 6'd1, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd0, 6'd1, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd1, 6'd1, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd8, 6'd1, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd15, 6'd63, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd3, 6'd0, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd2, 6'd7, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd2, 6'd6, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd4, 6'd29, 8'($urandom), 8'($urandom));
    send_request(REQ_SYMBOL, 4'd6, 6'd50, 8'($urandom), 8'($urandom));
    send_request(REQ_QUERY, 4'($urandom), 6'($urandom), 8'd0, 8'd185);
    send_request(REQ_QUERY, 4'($urandom), 6'($urandom), 8'd0, 8'd0);
    send_request(REQ_QUERY, 4'($urandom), 6'($urandom), 8'd18, 8'd18);
    send_request(REQ_QUERY, 4'($urandom), 6'($urandom), 8'd19, 8'd0);
    send_request(REQ_QUERY, 4'($urandom), 6'($urandom), 8'd255, 8'd255);
    send_request(REQ_QUERY, 4'($urandom), 6'($urandom), 8'd6, 8'd47);
  endtask

  // Queries on both sides of the readout bound for every display level.
  task automatic test_level_bounds();
    int unsigned lvl;
    int unsigned limit;
    for (int v = 0; v < 8; v++) begin
      set_display_level(3'(v));
      lvl = (v < MIN_LEVEL) ? MIN_LEVEL : v;
      limit = group_base[lvl + 1];
      send_request(REQ_QUERY, 4'($urandom), 6'($urandom), 8'(limit - 1), 8'(limit - 1));
      if (v % 2 == 0) begin
        send_request(REQ_QUERY, 4'($urandom), 6'($urandom), 8'(limit), 8'd0);
      end else begin
        send_request(REQ_QUERY, 4'($urandom), 6'($urandom), 8'd0, 8'(limit));
      end
    end
  endtask

  // Repeats one class back to back so its self-transition entry climbs step by step.
  task automatic test_repeated_class();
    int unsigned x;
    logic [3:0]  grp;
    logic [5:0]  num;
    x = $urandom_range(0, LAST_CLASS);
    class_of(x, grp, num);
    src_idling = 1'b0;
    sink_idling = 1'b0;
    repeat (RUN_LENGTH) begin
      send_request(REQ_SYMBOL, grp, num, 8'($urandom), 8'($urandom));
    end
    send_request(REQ_QUERY, 4'($urandom), 6'($urandom), 8'(x), 8'(x));
    src_idling = 1'b1;
    sink_idling = 1'b1;
  endtask

  // Phases of chains over a small class pool mixed with queries and noise.
  task automatic test_random_traffic();
    int unsigned pool [POOL_SIZE];
    int unsigned pick;
    int unsigned size;
    logic [3:0]  grp;
    logic [5:0]  num;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) begin
        set_display_level(3'd0);
      end else if (phase == 1) begin
        set_display_level(3'd7);
      end else begin
        set_display_level(3'($urandom_range(0, 7)));
      end
      // One middle phase and the closing one run without any idling.
      src_idling = !(phase == 3 || phase == NUM_PHASES - 1);
      sink_idling = src_idling;
      foreach (pool[i]) begin
        pool[i] = $urandom_range(0, LAST_CLASS);
      end
      if (phase % 2 == 0) begin
        pool[0] = 0;
        pool[1] = LAST_CLASS;
      end
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          class_of(pool[$urandom_range(0, POOL_SIZE - 1)], grp, num);
          send_request(REQ_SYMBOL, grp, num, 8'($urandom), 8'($urandom));
        end else if (pick < 68) begin
          send_request(REQ_SYMBOL, 4'($urandom), 6'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 72) begin
          // Valid group with a number past its size or zero.
          grp = 4'($urandom_range(1, HIGHEST_GROUP));
          size = group_base[grp + 1] - group_base[grp];
          num = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(size + 1, 63));
          send_request(REQ_SYMBOL, grp, num, 8'($urandom), 8'($urandom));
        end else if (pick < 93) begin
          send_request(REQ_QUERY, 4'($urandom), 6'($urandom),
                       8'(pool[$urandom_range(0, POOL_SIZE - 1)]),
                       8'(pool[$urandom_range(0, POOL_SIZE - 1)]));
        end else begin
          send_request(REQ_QUERY, 4'($urandom), 6'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    last_class = 0;
    last_valid = 1'b0;
    level_now = 3'd3;
    error_count = 0;
    idle_cycles = 0;
    sink_stall = 0;
    src_idling = 1'b1;
    sink_idling = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_chain_basics();
    test_level_bounds();
    test_repeated_class();
    test_random_traffic();

    src_idling = 1'b0;
    sink_idling = 1'b0;
    await_results();
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/ctc_pkg.sv
sv/ctc_front.sv
sv/ctc_queue.sv
sv/ctc_back.sv
sv/class_transition_counter.sv
sv/ctc_checker.sv
bench/testbench.sv
